[rtl/h2r_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB conversion package
// Shared constants, the hue sector code and the stage load group of the
// conversion pipeline.
// ----------------------------------------------------------------------------
package h2r_pkg;

   // Hue field: 1/16 degree units, 960 per sector (960 = 64 * 15)
   localparam int HUE_W        = 13;
   localparam int FRAC_W       = 10;
   localparam int SECTOR_STEP  = 960;
   localparam int SECTOR_COUNT = 6;
   localparam int HUE_LO_W     = 6;
   localparam int HUE_HI_W     = HUE_W - HUE_LO_W;
   localparam int SUB_STEP     = SECTOR_STEP / (1 << HUE_LO_W);
   localparam int QUOT_MAX     = ((1 << HUE_W) - 1) / SECTOR_STEP;
   localparam int QUOT_W       = 4;
   localparam int SECTOR_W     = 3;

   // Exact divide by 15 for operands below 2^20: x * ceil(2^24 / 15) >> 24
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP_W      = 21;
   localparam int RECIP_MULT   = ((1 << RECIP_SHIFT) + SUB_STEP - 1) / SUB_STEP;

   // Register stages from the input side to the output register
   localparam int PIPE_DEPTH   = 9;

   // Hue sector, named after the hue span it covers
   typedef enum logic [SECTOR_W-1:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   // Load enables of the term pipeline, one per stage
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
      logic s7;
      logic s8;
   } term_load_type;

   // Whole sectors in hue, from the hue bits above the low six (hue / 960)
   function automatic logic [QUOT_W-1:0] hue_quot(input logic [HUE_HI_W-1:0] hue_hi);
      logic [QUOT_W-1:0] quot;
      quot = '0;
      for (int i = 1; i <= QUOT_MAX; i++) begin
         if (hue_hi >= HUE_HI_W'(SUB_STEP * i)) begin
            quot = quot + QUOT_W'(1);
         end
      end
      return quot;
   endfunction

endpackage
`default_nettype wire

[rtl/h2r_sector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Hue sector decode
// Splits the hue into a sector (hue / 960 modulo 6) and the remainder
// within the sector, registered as the first pipeline stage.
// ----------------------------------------------------------------------------
module h2r_sector (
   input  logic                         clock,
   input  logic                         load,
   input  logic [h2r_pkg::HUE_W-1:0]    hue,
   output h2r_pkg::sector_type          sector,
   output logic [h2r_pkg::FRAC_W-1:0]   rem
);
   import h2r_pkg::*;

   logic [QUOT_W-1:0] quot;
   logic [QUOT_W-1:0] wrap;
   logic [HUE_W-1:0]  base;
   sector_type        sector_in;
   sector_type        sector_ff;
   logic [FRAC_W-1:0] rem_in;
   logic [FRAC_W-1:0] rem_ff;

   // Split hue into whole sectors and remainder
   always_comb begin
      quot      = hue_quot(hue[HUE_W-1:HUE_LO_W]);
      wrap      = (quot >= QUOT_W'(SECTOR_COUNT)) ? quot - QUOT_W'(SECTOR_COUNT) : quot;
      base      = HUE_W'(quot) * HUE_W'(SECTOR_STEP);
      rem_in    = FRAC_W'(hue - base);
      sector_in = sector_type'(wrap[SECTOR_W-1:0]);
   end

   // Hold while the stage is stalled
   always_ff @(posedge clock) begin
      if (load) begin
         sector_ff <= sector_in;
         rem_ff    <= rem_in;
      end
   end

   assign sector = sector_ff;
   assign rem    = rem_ff;

endmodule
`default_nettype wire

[rtl/h2r_term.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// HSV term pipeline
// Computes floor(v * (M*960 - s*f) / (M*960)) as v - ceil(v*s*f / (M*960)),
// with the ceiling division done as ceil by 64, by M, then by 15.
// ----------------------------------------------------------------------------
module h2r_term #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                         clock,
   input  h2r_pkg::term_load_type       load,
   input  logic [CHANNEL_BITS-1:0]      sat,
   input  logic [CHANNEL_BITS-1:0]      val,
   input  logic [h2r_pkg::FRAC_W-1:0]   frac,
   output logic [CHANNEL_BITS-1:0]      term
);
   import h2r_pkg::*;

   localparam int K       = CHANNEL_BITS;
   localparam int M_INT   = (1 << K) - 1;
   localparam int VS_W    = 2 * K;
   localparam int X_W     = VS_W + FRAC_W;
   localparam int Y_W     = VS_W + 5;
   localparam int HI_W    = Y_W - K;
   localparam int R_W     = K + 6;
   localparam int R2_W    = K + 7;
   localparam int HH_W    = K + 6;
   localparam int U_W     = K + 4;
   localparam int UP_W    = K + 5;
   localparam int PROD_W  = UP_W + RECIP_W;

   // Stage 2: v*s
   logic [VS_W-1:0]   vs_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [K-1:0]      v2_ff;
   // Stage 3: v*s*f
   logic [X_W-1:0]    x_in;
   logic [X_W-1:0]    x_ff;
   logic [K-1:0]      v3_ff;
   // Stage 4: ceil by 64, first fold by M
   logic [X_W:0]      x_up;
   logic [Y_W-1:0]    y_div;
   logic [Y_W-1:0]    y_bias;
   logic [HI_W-1:0]   hi_in;
   logic [R_W-1:0]    r_in;
   logic [HI_W-1:0]   hi_ff;
   logic [R_W-1:0]    r_ff;
   logic [K-1:0]      v4_ff;
   // Stage 5: second fold by M
   logic [R_W-K-1:0]  h2;
   logic [R2_W-1:0]   r2_in;
   logic [HH_W-1:0]   hh_in;
   logic [R2_W-1:0]   r2_ff;
   logic [HH_W-1:0]   hh_ff;
   logic [K-1:0]      v5_ff;
   // Stage 6: final correction of the quotient by M
   logic [1:0]        corr;
   logic [U_W-1:0]    u_in;
   logic [U_W-1:0]    u_ff;
   logic [K-1:0]      v6_ff;
   // Stage 7: reciprocal product for ceil by 15
   logic [UP_W-1:0]   u_bias;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;
   logic [K-1:0]      v7_ff;
   // Stage 8: term
   logic [K-1:0]      cq;
   logic [K-1:0]      term_in;
   logic [K-1:0]      term_ff;

   // Fold arithmetic: y = hi*(M+1) + lo = hi*M + (hi + lo)
   always_comb begin
      x_in    = X_W'(vs_ff) * X_W'(frac_ff);

      x_up    = (X_W+1)'(x_ff) + (X_W+1)'((1 << HUE_LO_W) - 1);
      y_div   = Y_W'(x_up >> HUE_LO_W);
      y_bias  = y_div + Y_W'(M_INT - 1);
      hi_in   = y_bias[Y_W-1:K];
      r_in    = R_W'(hi_in) + R_W'(y_bias[K-1:0]);

      h2      = r_ff[R_W-1:K];
      r2_in   = R2_W'(h2) + R2_W'(r_ff[K-1:0]);
      hh_in   = HH_W'(hi_ff) + HH_W'(h2);

      corr    = 2'(r2_ff >= R2_W'(M_INT)) + 2'(r2_ff >= R2_W'(2 * M_INT))
              + 2'(r2_ff >= R2_W'(3 * M_INT));
      u_in    = U_W'(hh_ff + HH_W'(corr));

      u_bias  = UP_W'(u_ff) + UP_W'(SUB_STEP - 1);
      prod_in = PROD_W'(u_bias) * PROD_W'(RECIP_MULT);

      cq      = prod_ff[RECIP_SHIFT +: K];
      term_in = v7_ff - cq;
   end

   // Advance each stage on its own load enable
   always_ff @(posedge clock) begin
      if (load.s2) begin
         vs_ff   <= VS_W'(sat) * VS_W'(val);
         frac_ff <= frac;
         v2_ff   <= val;
      end
      if (load.s3) begin
         x_ff  <= x_in;
         v3_ff <= v2_ff;
      end
      if (load.s4) begin
         hi_ff <= hi_in;
         r_ff  <= r_in;
         v4_ff <= v3_ff;
      end
      if (load.s5) begin
         r2_ff <= r2_in;
         hh_ff <= hh_in;
         v5_ff <= v4_ff;
      end
      if (load.s6) begin
         u_ff  <= u_in;
         v6_ff <= v5_ff;
      end
      if (load.s7) begin
         prod_ff <= prod_in;
         v7_ff   <= v6_ff;
      end
      if (load.s8) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule
`default_nettype wire

[rtl/hsv_to_rgb_color_convert_top.sv]
`default_nettype none
// Throughput: one item per cycle unless a stalled result holds every stage back to
// stage 1; nine register stages, each with its own valid bit.
// A stalled result holds only the stages behind it that are full; empty stages fill.
// Reset clears the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// HSV to RGB color conversion, top level
// Sector decode, three term pipelines (p, q, t), sector select and output
// register, with per-stage valid and ready.
// ----------------------------------------------------------------------------
module hsv_to_rgb_color_convert_top #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // hue, saturation, brightness, opacity (from bit 0 up), zero padded
   input  logic [((h2r_pkg::HUE_W + 3*CHANNEL_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // red, green, blue, alpha_out (from bit 0 up), zero padded
   output logic [((4*CHANNEL_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import h2r_pkg::*;

   localparam int K       = CHANNEL_BITS;
   localparam int SAT_LSB = HUE_W;
   localparam int VAL_LSB = HUE_W + K;
   localparam int ALP_LSB = HUE_W + 2 * K;
   localparam int RSP_W   = ((4 * K + 7) / 8) * 8;
   localparam int LAST    = PIPE_DEPTH - 1;

   logic [PIPE_DEPTH:1]   vld_ff;
   logic [PIPE_DEPTH:1]   vld_in;
   logic [PIPE_DEPTH+1:1] ready;
   term_load_type         term_load;

   logic [K-1:0]          sat1_ff;
   logic [K-1:0]          val1_ff;
   logic [K-1:0]          alp1_ff;
   sector_type            sector1;
   logic [FRAC_W-1:0]     rem1;

   sector_type            sec_ff [LAST:2];
   logic [K-1:0]          vch_ff [LAST:2];
   logic [K-1:0]          alp_ff [LAST:2];

   logic [FRAC_W-1:0]     frac_q;
   logic [FRAC_W-1:0]     frac_t;
   logic [K-1:0]          term_p;
   logic [K-1:0]          term_q;
   logic [K-1:0]          term_t;

   logic [K-1:0]          red_in;
   logic [K-1:0]          green_in;
   logic [K-1:0]          blue_in;
   logic [4*K-1:0]        out_ff;

   // A stage may load when it is empty or the stage after it moves
   always_comb begin
      ready[PIPE_DEPTH+1] = rsp_tready;
      for (int i = PIPE_DEPTH; i >= 1; i--) begin
         ready[i] = !vld_ff[i] || ready[i+1];
      end
      for (int i = 1; i <= PIPE_DEPTH; i++) begin
         if (!ready[i]) begin
            vld_in[i] = vld_ff[i];
         end else if (i == 1) begin
            vld_in[i] = req_tvalid;
         end else begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   assign req_tready   = ready[1];
   assign term_load.s2 = ready[2];
   assign term_load.s3 = ready[3];
   assign term_load.s4 = ready[4];
   assign term_load.s5 = ready[5];
   assign term_load.s6 = ready[6];
   assign term_load.s7 = ready[7];
   assign term_load.s8 = ready[8];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: capture channels beside the sector decode
   always_ff @(posedge clock) begin
      if (ready[1]) begin
         sat1_ff <= req_tdata[SAT_LSB +: K];
         val1_ff <= req_tdata[VAL_LSB +: K];
         alp1_ff <= req_tdata[ALP_LSB +: K];
      end
   end

   h2r_sector u_sector (
      .clock  (clock),
      .load   (ready[1]),
      .hue    (req_tdata[HUE_W-1:0]),
      .sector (sector1),
      .rem    (rem1)
   );

   // Carry sector, value and alpha alongside the term pipelines
   always_ff @(posedge clock) begin
      if (ready[2]) begin
         sec_ff[2] <= sector1;
         vch_ff[2] <= val1_ff;
         alp_ff[2] <= alp1_ff;
      end
      for (int i = 3; i <= LAST; i++) begin
         if (ready[i]) begin
            sec_ff[i] <= sec_ff[i-1];
            vch_ff[i] <= vch_ff[i-1];
            alp_ff[i] <= alp_ff[i-1];
         end
      end
   end

   // p uses the whole sector width, q the remainder, t its complement
   assign frac_q = rem1;
   assign frac_t = FRAC_W'(SECTOR_STEP) - rem1;

   h2r_term #(.CHANNEL_BITS(CHANNEL_BITS)) u_term_p (
      .clock (clock),
      .load  (term_load),
      .sat   (sat1_ff),
      .val   (val1_ff),
      .frac  (FRAC_W'(SECTOR_STEP)),
      .term  (term_p)
   );

   h2r_term #(.CHANNEL_BITS(CHANNEL_BITS)) u_term_q (
      .clock (clock),
      .load  (term_load),
      .sat   (sat1_ff),
      .val   (val1_ff),
      .frac  (frac_q),
      .term  (term_q)
   );

   h2r_term #(.CHANNEL_BITS(CHANNEL_BITS)) u_term_t (
      .clock (clock),
      .load  (term_load),
      .sat   (sat1_ff),
      .val   (val1_ff),
      .frac  (frac_t),
      .term  (term_t)
   );

   // Order v, p, q, t by sector
   always_comb begin
      case (sec_ff[LAST])
         SEC_RED_YEL: begin
            red_in = vch_ff[LAST]; green_in = term_t;       blue_in = term_p;
         end
         SEC_YEL_GRN: begin
            red_in = term_q;       green_in = vch_ff[LAST]; blue_in = term_p;
         end
         SEC_GRN_CYN: begin
            red_in = term_p;       green_in = vch_ff[LAST]; blue_in = term_t;
         end
         SEC_CYN_BLU: begin
            red_in = term_p;       green_in = term_q;       blue_in = vch_ff[LAST];
         end
         SEC_BLU_MAG: begin
            red_in = term_t;       green_in = term_p;       blue_in = vch_ff[LAST];
         end
         default: begin
            red_in = vch_ff[LAST]; green_in = term_p;       blue_in = term_q;
         end
      endcase
   end

   // Output register: hold while the result is not taken
   always_ff @(posedge clock) begin
      if (ready[PIPE_DEPTH]) begin
         out_ff <= {alp_ff[LAST], blue_in, green_in, red_in};
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_DEPTH];
   assign rsp_tdata  = RSP_W'(out_ff);

endmodule
`default_nettype wire

[rtl/h2r_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB port checker
// Watches the top level ports: reset, output stall, input ready and the
// number of items inside the pipeline.
// ----------------------------------------------------------------------------
module h2r_checker #(
   parameter int CHANNEL_BITS = 8
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((4*CHANNEL_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import h2r_pkg::*;

   localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic             in_acc;
   logic             out_acc;

   // Count items accepted and not yet delivered
   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;
   assign occ_in  = occ_ff + OCC_W'(in_acc) - OCC_W'(out_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input blocked while output is free");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(PIPE_DEPTH))
      else $error("more items inside than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ_ff != '0)
      else $error("result without an accepted item");

endmodule

bind hsv_to_rgb_color_convert_top h2r_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_h2r_checker (.*);
`default_nettype wire
